>>> hw/rtl/playfair_encrypt_defines.svh
// Assertion macros shared by the playfair encryptor checker files.
// Depends on nothing; included by the files that hold assertions.
`ifndef PLAYFAIR_ENCRYPT_DEFINES_SVH
`define PLAYFAIR_ENCRYPT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PFE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("playfair_encrypt check failed");

// next-cycle implication, off while reset is high
`define PFE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("playfair_encrypt check failed");

`endif

>>> hw/rtl/pfe_pkg.sv
// Types, constants and small helper functions for the playfair encryptor.
// Depends on nothing; used by every module of the block.
package pfe_pkg;

   // square geometry
   localparam int SQUARE_SIDE  = 5;
   localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
   localparam int ALPHABET     = 26;
   localparam int ROW_W        = $clog2(SQUARE_SIDE);
   localparam int CELL_W       = $clog2(SQUARE_CELLS);

   // letter codes
   localparam logic [4:0] CODE_I     = 5'd8;
   localparam logic [4:0] CODE_J     = 5'd9;
   localparam logic [4:0] CODE_X     = 5'd23;
   localparam logic [4:0] CODE_SPACE = 5'd26;
   localparam logic [4:0] LAST_CODE  = 5'(ALPHABET - 1);

   // command codes
   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_KEY    = 3'd1;
   localparam logic [2:0] CMD_FINISH = 3'd2;
   localparam logic [2:0] CMD_TEXT   = 3'd3;
   localparam logic [2:0] CMD_END    = 3'd4;

   // rule codes
   localparam logic [1:0] RULE_ROW    = 2'd0;
   localparam logic [1:0] RULE_COLUMN = 2'd1;
   localparam logic [1:0] RULE_RECT   = 2'd2;

   typedef struct packed {
      logic [2:0] command;
      logic [4:0] letter;
   } pfe_req_type;

   typedef struct packed {
      logic [4:0] cipher_letter;
      logic [1:0] rule_used;
      logic       last_of_pair;
   } pfe_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic fill_step;
      logic look;
      logic calc;
      logic load_first;
      logic load_second;
   } pfe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_start;
      logic pair_start;
      logic walk_last;
   } pfe_status_type;

   // row of a cell index, by compare chain
   function automatic logic [ROW_W-1:0] row_of(input logic [CELL_W-1:0] p);
      logic [ROW_W-1:0] r;
      r = '0;
      for (int k = 1; k < SQUARE_SIDE; k++) begin
         if (p >= CELL_W'(k * SQUARE_SIDE)) r = ROW_W'(k);
      end
      return r;
   endfunction

   // column of a cell index
   function automatic logic [ROW_W-1:0] col_of(input logic [CELL_W-1:0] p);
      return ROW_W'(int'(p) - int'(row_of(p)) * SQUARE_SIDE);
   endfunction

   // next row or column with wrap
   function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] x);
      return (x == ROW_W'(SQUARE_SIDE - 1)) ? '0 : ROW_W'(x + 1'b1);
   endfunction

   // cell index of a row and column
   function automatic logic [CELL_W-1:0] cell_at(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] c);
      return CELL_W'(int'(r) * SQUARE_SIDE + int'(c));
   endfunction

endpackage

>>> hw/rtl/pfe_ctrl.sv
// Controller state machine of the playfair encryptor.
// Depends on pfe_pkg; drives the datapath commands and both handshakes.
module pfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pfe_pkg::pfe_status_type status,
   output pfe_pkg::pfe_cmd_type    cmd
);
   import pfe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK,
      ST_CALC,
      ST_SEND_FIRST,
      ST_SEND_SECOND
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && req_ready_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // datapath commands
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.fill_step   = (state_ff == ST_FILL);
      cmd.look        = (state_ff == ST_LOOK);
      cmd.calc        = (state_ff == ST_CALC);
      cmd.load_first  = (state_ff == ST_SEND_FIRST) && out_free;
      cmd.load_second = (state_ff == ST_SEND_SECOND) && out_free;
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_first || cmd.load_second) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && status.walk_start) begin
                  state_ff     <= ST_FILL;
                  req_ready_ff <= 1'b0;
               end else if (accept && status.pair_start) begin
                  state_ff     <= ST_LOOK;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_FILL: begin
               if (status.walk_last) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            ST_LOOK: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               state_ff <= ST_SEND_FIRST;
            end
            ST_SEND_FIRST: begin
               if (out_free) state_ff <= ST_SEND_SECOND;
            end
            ST_SEND_SECOND: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/pfe_datapath.sv
// Datapath of the playfair encryptor: key square and position memories,
// placed marks, pending letter, pair lookup and the output register.
// Depends on pfe_pkg; steered by pfe_ctrl.
module pfe_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  pfe_pkg::pfe_req_type    req_data,
   input  pfe_pkg::pfe_cmd_type    cmd,
   output pfe_pkg::pfe_status_type status,
   output pfe_pkg::pfe_rsp_type    rsp_data
);
   import pfe_pkg::*;

   // memories, contents undefined until written
   logic [4:0]        square_mem [SQUARE_CELLS];
   logic [CELL_W-1:0] pos_mem    [ALPHABET];

   logic [ALPHABET-1:0] placed_ff;
   logic [CELL_W:0]     fill_ff;
   logic [4:0]          pend_ff;
   logic                pend_valid_ff;
   logic [4:0]          walk_ff;
   logic [4:0]          pair_a_ff;
   logic [4:0]          pair_b_ff;
   logic [CELL_W-1:0]   pos_a_ff;
   logic [CELL_W-1:0]   pos_b_ff;
   logic [4:0]          ciph_a_ff;
   logic [4:0]          ciph_b_ff;
   logic [1:0]          rule_ff;
   pfe_rsp_type         rsp_ff;

   logic [4:0]        text_letter;
   logic              text_ok;
   logic              is_clear;
   logic              is_text;
   logic              is_end;
   logic [4:0]        place_letter;
   logic              place_req;
   logic              place_en;
   logic [CELL_W-1:0] fill_addr;
   logic [CELL_W-1:0] cell_a;
   logic [CELL_W-1:0] cell_b;
   logic [ROW_W-1:0]  row_a;
   logic [ROW_W-1:0]  row_b;
   logic [ROW_W-1:0]  col_a;
   logic [ROW_W-1:0]  col_b;
   logic [CELL_W-1:0] out_a;
   logic [CELL_W-1:0] out_b;
   logic [1:0]        rule;

   // input decode
   always_comb begin
      if (req_data.letter == CODE_SPACE) begin
         text_letter = CODE_X;
      end else if (req_data.letter == CODE_J) begin
         text_letter = CODE_I;
      end else begin
         text_letter = req_data.letter;
      end
      text_ok  = (req_data.letter <= CODE_SPACE);
      is_clear = cmd.accept && (req_data.command == CMD_CLEAR);
      is_text  = cmd.accept && (req_data.command == CMD_TEXT) && text_ok;
      is_end   = cmd.accept && (req_data.command == CMD_END);
   end

   always_comb begin
      status            = '0;
      status.walk_start = cmd.accept && (req_data.command == CMD_FINISH);
      status.pair_start = (is_text || is_end) && pend_valid_ff;
      status.walk_last  = (walk_ff == LAST_CODE);
   end

   // placement of a key letter or of the walk letter
   always_comb begin
      if (cmd.fill_step) begin
         place_letter = walk_ff;
         place_req    = (walk_ff != CODE_J);
      end else begin
         place_letter = (req_data.letter == CODE_J) ? CODE_I : req_data.letter;
         place_req    = cmd.accept && (req_data.command == CMD_KEY) &&
                        (req_data.letter <= LAST_CODE);
      end
      place_en  = place_req && (fill_ff < (CELL_W+1)'(SQUARE_CELLS)) &&
                  !placed_ff[place_letter];
      fill_addr = fill_ff[CELL_W-1:0];
   end

   // key state, pending letter and walk counter
   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff     <= '0;
         fill_ff       <= '0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         walk_ff       <= '0;
      end else begin
         if (is_clear) begin
            placed_ff     <= '0;
            fill_ff       <= '0;
            pend_ff       <= '0;
            pend_valid_ff <= 1'b0;
         end else if (place_en) begin
            placed_ff[place_letter] <= 1'b1;
            fill_ff                 <= fill_ff + 1'b1;
         end
         if (is_text) begin
            if (!pend_valid_ff) begin
               pend_ff       <= text_letter;
               pend_valid_ff <= 1'b1;
            end else if (pend_ff != text_letter) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (is_end) pend_valid_ff <= 1'b0;
         if (status.walk_start) begin
            walk_ff <= '0;
         end else if (cmd.fill_step) begin
            walk_ff <= walk_ff + 1'b1;
         end
      end
   end

   // pair letters; a doubled letter pairs with x and stays pending
   always_ff @(posedge clock) begin
      if (status.pair_start) begin
         pair_a_ff <= pend_ff;
         if (is_text && (pend_ff != text_letter)) begin
            pair_b_ff <= text_letter;
         end else begin
            pair_b_ff <= CODE_X;
         end
      end
   end

   // cell arithmetic on the looked-up positions
   always_comb begin
      cell_a = (pos_a_ff < CELL_W'(SQUARE_CELLS)) ? pos_a_ff : '0;
      cell_b = (pos_b_ff < CELL_W'(SQUARE_CELLS)) ? pos_b_ff : '0;
      row_a  = row_of(cell_a);
      row_b  = row_of(cell_b);
      col_a  = col_of(cell_a);
      col_b  = col_of(cell_b);
      if (row_a == row_b) begin
         out_a = cell_at(row_a, wrap_inc(col_a));
         out_b = cell_at(row_b, wrap_inc(col_b));
         rule  = RULE_ROW;
      end else if (col_a == col_b) begin
         out_a = cell_at(wrap_inc(row_a), col_a);
         out_b = cell_at(wrap_inc(row_b), col_b);
         rule  = RULE_COLUMN;
      end else begin
         out_a = cell_at(row_a, col_b);
         out_b = cell_at(row_b, col_a);
         rule  = RULE_RECT;
      end
   end

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_addr]  <= place_letter;
         pos_mem[place_letter]  <= fill_addr;
      end
      if (cmd.look) begin
         pos_a_ff <= pos_mem[pair_a_ff];
         pos_b_ff <= pos_mem[pair_b_ff];
      end
      if (cmd.calc) begin
         ciph_a_ff <= square_mem[out_a];
         ciph_b_ff <= square_mem[out_b];
         rule_ff   <= rule;
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (cmd.load_first) begin
         rsp_ff.cipher_letter <= ciph_a_ff;
         rsp_ff.rule_used     <= rule_ff;
         rsp_ff.last_of_pair  <= 1'b0;
      end else if (cmd.load_second) begin
         rsp_ff.cipher_letter <= ciph_b_ff;
         rsp_ff.rule_used     <= rule_ff;
         rsp_ff.last_of_pair  <= 1'b1;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/playfair_encrypt.sv
// Playfair encryptor over a 5x5 key square. Command beats clear the square,
// add key letters (j folded into i, repeats dropped) and finish the key,
// which walks a..z once and places every unused letter, one letter a cycle.
// Plaintext beats (space read as x) are paired; a doubled letter pairs with
// x and stays pending, and end of message pads a lone letter with x. Each
// pair gives two result beats, the second flagged last_of_pair. Finish key
// runs the 26-letter walk through the single-write-port memories. A beat
// that closes a pair passes a registered position read, a registered square
// read, then two output beats through the output register. The output
// register lets a new item in while the last beat of a pair still waits to
// be taken.
// Depends on pfe_pkg, pfe_ctrl and pfe_datapath.
module playfair_encrypt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pfe_pkg::pfe_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfe_pkg::pfe_rsp_type rsp_data
);
   import pfe_pkg::*;

   pfe_cmd_type    cmd;
   pfe_status_type status;

   // control
   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   pfe_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> hw/rtl/pfe_checker.sv
// Port-level checks of the playfair encryptor, bound to the top level.
// Depends on pfe_pkg and playfair_encrypt_defines.svh.
`include "playfair_encrypt_defines.svh"

module pfe_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input pfe_pkg::pfe_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pfe_pkg::pfe_rsp_type rsp_data
);
   import pfe_pkg::*;

   // a stalled result beat holds
   `PFE_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // result codes stay in range
   `PFE_ASSERT_IMPL(rsp_range_a, clock, reset, rsp_valid, (rsp_data.cipher_letter <= LAST_CODE) && (rsp_data.rule_used <= RULE_RECT))

   // first beat of a pair is followed at once by the second, same rule
   `PFE_ASSERT_NEXT(pair_second_a, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_of_pair, rsp_valid && rsp_data.last_of_pair && (rsp_data.rule_used == $past(rsp_data.rule_used)))

   // a closed pair is never followed by another second beat
   `PFE_ASSERT_NEXT(pair_first_a, clock, reset, rsp_valid && rsp_ready && rsp_data.last_of_pair, !(rsp_valid && rsp_data.last_of_pair))

   // an accepted finish beat closes the input during the key walk
   `PFE_ASSERT_NEXT(finish_stall_a, clock, reset, req_valid && req_ready && (req_data.command == CMD_FINISH), !req_ready)

endmodule

bind playfair_encrypt pfe_checker u_pfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
